// ===== rtl/ata_ps_pkg.sv =====
// ----------------------------------------------------------------------------
// ata_ps_pkg: shared types and constants of the ATA PIO host sequencer
// Opcode and result kind codes, drive register codes, status bits,
// command bytes, the phase type and the result burst type.
// ----------------------------------------------------------------------------
package ata_ps_pkg;

	// input opcodes
	localparam logic [2:0] OP_IDENTIFY  = 3'd0;
	localparam logic [2:0] OP_READ      = 3'd1;
	localparam logic [2:0] OP_WRITE     = 3'd2;
	localparam logic [2:0] OP_BUS_RET   = 3'd3;
	localparam logic [2:0] OP_HOST_WORD = 3'd4;

	// result kinds
	localparam logic [2:0] K_BUS_RD  = 3'd0;
	localparam logic [2:0] K_BUS_WR  = 3'd1;
	localparam logic [2:0] K_TO_HOST = 3'd2;
	localparam logic [2:0] K_WANT    = 3'd3;
	localparam logic [2:0] K_ID_DONE = 3'd4;
	localparam logic [2:0] K_WR_DONE = 3'd5;

	// drive register codes
	localparam logic [4:0] REG_DATA    = 5'h02;
	localparam logic [4:0] REG_SECTORS = 5'h0A;
	localparam logic [4:0] REG_LBA0    = 5'h0E;
	localparam logic [4:0] REG_LBA1    = 5'h12;
	localparam logic [4:0] REG_LBA2    = 5'h16;
	localparam logic [4:0] REG_LBA3    = 5'h1A;
	localparam logic [4:0] REG_CMD     = 5'h1E;

	// status register bits
	localparam int ST_DRQ_BIT  = 3;
	localparam int ST_DRDY_BIT = 6;
	localparam int ST_BSY_BIT  = 7;

	// device select and command bytes
	localparam logic [7:0] DEV_SEL_CHS  = 8'hA0;
	localparam logic [7:0] DEV_SEL_LBA  = 8'hE0;
	localparam logic [7:0] CMD_READ     = 8'h20;
	localparam logic [7:0] CMD_WRITE    = 8'h30;
	localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
	localparam logic [7:0] SECTOR_ONE   = 8'h01;

	// identify words of interest
	localparam logic [8:0] ID_WORD_CAPS    = 9'd49;
	localparam logic [8:0] ID_WORD_SECT_LO = 9'd60;
	localparam logic [8:0] ID_WORD_SECT_HI = 9'd61;
	localparam int         ID_LBA_BIT      = 9;

	typedef enum logic [9:0] {
		PH_IDLE    = 10'b00_0000_0001,
		PH_ID_DRDY = 10'b00_0000_0010,
		PH_ID_BSY  = 10'b00_0000_0100,
		PH_ID_DRQ  = 10'b00_0000_1000,
		PH_ID_DATA = 10'b00_0001_0000,
		PH_RW_BSY  = 10'b00_0010_0000,
		PH_RW_DRQ  = 10'b00_0100_0000,
		PH_RW_BSY2 = 10'b00_1000_0000,
		PH_RD_DATA = 10'b01_0000_0000,
		PH_WR_DATA = 10'b10_0000_0000
	} phase_t;

	localparam int BURST_MAX = 7;
	localparam int CNT_W     = $clog2(BURST_MAX + 1);
	localparam int IDX_W     = $clog2(BURST_MAX);

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  addr;
		logic [15:0] data;
		logic        last;
	} res_entry_t;

	typedef struct packed {
		res_entry_t [BURST_MAX-1:0] ent;
		logic [CNT_W-1:0]           count;
		logic                       lba_sup;
		logic [31:0]                sectors;
	} burst_t;

	function automatic res_entry_t mk_res(input logic [2:0] kind, input logic [4:0] addr,
		input logic [15:0] data, input logic last);
		res_entry_t r;
		r.kind = kind;
		r.addr = addr;
		r.data = data;
		r.last = last;
		return r;
	endfunction

endpackage

// ===== rtl/ata_ps_step.sv =====
// ----------------------------------------------------------------------------
// ata_ps_step: sequencer state and per-item result burst
// Holds the transfer state and, for the item presented, works out the next
// state and the list of results that the item causes.
// ----------------------------------------------------------------------------
module ata_ps_step import ata_ps_pkg::*; #(
	parameter int BLOCK_WORDS    = 256,
	parameter int IDENTIFY_WORDS = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [2:0]  opcode,
	input  logic [27:0] lba,
	input  logic [15:0] bus_word,
	input  logic [15:0] host_word,
	output burst_t      burst
);

	phase_t      phase_q, phase_d;
	logic [1:0]  operation_q, operation_d;
	logic [8:0]  word_index_q, word_index_d;
	logic [27:0] block_address_q, block_address_d;
	logic        lba_flag_q, lba_flag_d;
	logic [31:0] sector_total_q, sector_total_d;
	logic [8:0]  idx_inc;

	assign idx_inc = word_index_q + 9'd1;

	always_comb begin
		phase_d         = phase_q;
		operation_d     = operation_q;
		word_index_d    = word_index_q;
		block_address_d = block_address_q;
		lba_flag_d      = lba_flag_q;
		sector_total_d  = sector_total_q;
		burst           = '0;
		case (opcode)
			OP_IDENTIFY: begin
				if (phase_q == PH_IDLE) begin
					operation_d  = 2'd0;
					burst.ent[0] = mk_res(K_BUS_WR, REG_LBA3, {8'h00, DEV_SEL_CHS}, 1'b0);
					burst.ent[1] = mk_res(K_BUS_RD, REG_CMD, 16'h0000, 1'b0);
					burst.count  = CNT_W'(2);
					phase_d      = PH_ID_DRDY;
				end
			end
			OP_READ, OP_WRITE: begin
				if (phase_q == PH_IDLE) begin
					operation_d     = opcode[1:0];
					block_address_d = lba;
					burst.ent[0]    = mk_res(K_BUS_RD, REG_CMD, 16'h0000, 1'b0);
					burst.count     = CNT_W'(1);
					phase_d         = PH_RW_BSY;
				end
			end
			OP_BUS_RET: begin
				// default: one more status poll
				burst.ent[0] = mk_res(K_BUS_RD, REG_CMD, 16'h0000, 1'b0);
				burst.count  = CNT_W'(1);
				case (phase_q)
					PH_ID_DRDY: begin
						if (bus_word[ST_DRDY_BIT])
							phase_d = PH_ID_BSY;
					end
					PH_ID_BSY: begin
						if (!bus_word[ST_BSY_BIT]) begin
							burst.ent[0] = mk_res(K_BUS_WR, REG_CMD, {8'h00, CMD_IDENTIFY},
								1'b0);
							burst.ent[1] = mk_res(K_BUS_RD, REG_CMD, 16'h0000, 1'b0);
							burst.count  = CNT_W'(2);
							phase_d      = PH_ID_DRQ;
						end
					end
					PH_ID_DRQ: begin
						if (bus_word[ST_DRQ_BIT]) begin
							word_index_d = '0;
							burst.ent[0] = mk_res(K_BUS_RD, REG_DATA, 16'h0000, 1'b0);
							phase_d      = PH_ID_DATA;
						end
					end
					PH_ID_DATA: begin
						if (word_index_q == ID_WORD_CAPS)
							lba_flag_d = bus_word[ID_LBA_BIT];
						else if (word_index_q == ID_WORD_SECT_LO)
							sector_total_d = {sector_total_q[31:16], bus_word};
						else if (word_index_q == ID_WORD_SECT_HI)
							sector_total_d = {bus_word, sector_total_q[15:0]};
						if (idx_inc < 9'(IDENTIFY_WORDS) && idx_inc != '0) begin
							word_index_d = idx_inc;
							burst.ent[0] = mk_res(K_BUS_RD, REG_DATA, 16'h0000, 1'b0);
						end else begin
							word_index_d = '0;
							burst.ent[0] = mk_res(K_ID_DONE, 5'h00, 16'h0000, 1'b1);
							phase_d      = PH_IDLE;
						end
					end
					PH_RW_BSY: begin
						if (!bus_word[ST_BSY_BIT]) begin
							burst.ent[0] = mk_res(K_BUS_WR, REG_SECTORS, {8'h00, SECTOR_ONE},
								1'b0);
							burst.ent[1] = mk_res(K_BUS_WR, REG_LBA0,
								{8'h00, block_address_q[7:0]}, 1'b0);
							burst.ent[2] = mk_res(K_BUS_WR, REG_LBA1,
								{8'h00, block_address_q[15:8]}, 1'b0);
							burst.ent[3] = mk_res(K_BUS_WR, REG_LBA2,
								{8'h00, block_address_q[23:16]}, 1'b0);
							burst.ent[4] = mk_res(K_BUS_WR, REG_LBA3,
								{8'h00, DEV_SEL_LBA[7:4], block_address_q[27:24]}, 1'b0);
							burst.ent[5] = mk_res(K_BUS_WR, REG_CMD,
								{8'h00, (operation_q == OP_WRITE[1:0]) ? CMD_WRITE : CMD_READ},
								1'b0);
							burst.ent[6] = mk_res(K_BUS_RD, REG_CMD, 16'h0000, 1'b0);
							burst.count  = CNT_W'(7);
							phase_d      = PH_RW_DRQ;
						end
					end
					PH_RW_DRQ: begin
						if (bus_word[ST_DRQ_BIT])
							phase_d = PH_RW_BSY2;
					end
					PH_RW_BSY2: begin
						if (!bus_word[ST_BSY_BIT]) begin
							word_index_d = '0;
							if (operation_q == OP_WRITE[1:0]) begin
								burst.ent[0] = mk_res(K_WANT, 5'h00, 16'h0000, 1'b0);
								phase_d      = PH_WR_DATA;
							end else begin
								burst.ent[0] = mk_res(K_BUS_RD, REG_DATA, 16'h0000, 1'b0);
								phase_d      = PH_RD_DATA;
							end
						end
					end
					PH_RD_DATA: begin
						if (idx_inc >= 9'(BLOCK_WORDS) || idx_inc == '0) begin
							word_index_d = '0;
							burst.ent[0] = mk_res(K_TO_HOST, 5'h00, bus_word, 1'b1);
							phase_d      = PH_IDLE;
						end else begin
							word_index_d = idx_inc;
							burst.ent[0] = mk_res(K_TO_HOST, 5'h00, bus_word, 1'b0);
							burst.ent[1] = mk_res(K_BUS_RD, REG_DATA, 16'h0000, 1'b0);
							burst.count  = CNT_W'(2);
						end
					end
					default: begin
						// no bus read pending: drop the word
						burst.count = '0;
					end
				endcase
			end
			OP_HOST_WORD: begin
				if (phase_q == PH_WR_DATA) begin
					if (idx_inc >= 9'(BLOCK_WORDS) || idx_inc == '0) begin
						word_index_d = '0;
						burst.ent[0] = mk_res(K_BUS_WR, REG_DATA, host_word, 1'b1);
						burst.ent[1] = mk_res(K_WR_DONE, 5'h00, 16'h0000, 1'b1);
						phase_d      = PH_IDLE;
					end else begin
						word_index_d = idx_inc;
						burst.ent[0] = mk_res(K_BUS_WR, REG_DATA, host_word, 1'b0);
						burst.ent[1] = mk_res(K_WANT, 5'h00, 16'h0000, 1'b0);
					end
					burst.count = CNT_W'(2);
				end
			end
			default: begin
				burst.count = '0;
			end
		endcase
		burst.lba_sup = lba_flag_d;
		burst.sectors = sector_total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			operation_q     <= '0;
			word_index_q    <= '0;
			block_address_q <= '0;
			lba_flag_q      <= 1'b0;
			sector_total_q  <= '0;
		end else if (fire) begin
			phase_q         <= phase_d;
			operation_q     <= operation_d;
			word_index_q    <= word_index_d;
			block_address_q <= block_address_d;
			lba_flag_q      <= lba_flag_d;
			sector_total_q  <= sector_total_d;
		end
	end

	a_index_in_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(word_index_q != '0) |->
		(phase_q == PH_ID_DATA || phase_q == PH_RD_DATA || phase_q == PH_WR_DATA))
		else $error("word index running outside a data phase");

	a_phase_move_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_d != phase_q) |-> (burst.count != '0))
		else $error("phase advanced without any result");

endmodule

// ===== rtl/ata_ps_out.sv =====
// ----------------------------------------------------------------------------
// ata_ps_out: result burst register and output drain
// Holds one item's results and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module ata_ps_out import ata_ps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  burst_t      burst,
	output logic        free,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [4:0]  bus_address,
	output logic [15:0] bus_data,
	output logic [15:0] host_data,
	output logic        lba_supported,
	output logic [31:0] disk_sectors,
	output logic        last
);

	res_entry_t [BURST_MAX-1:0] ent_q;
	logic                       lba_sup_q;
	logic [31:0]                sectors_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           idx_q;
	logic [CNT_W-1:0]           idx_inc;
	logic                       pop;
	res_entry_t                 cur;

	assign out_valid = (idx_q != cnt_q);
	assign pop       = out_valid && !out_stall;
	assign idx_inc   = idx_q + CNT_W'(1);
	assign free      = !out_valid || (pop && idx_inc == cnt_q);
	assign cur       = ent_q[idx_q[IDX_W-1:0]];

	assign kind          = cur.kind;
	assign bus_address   = cur.addr;
	assign last          = cur.last;
	assign bus_data      = (cur.kind == K_BUS_WR) ? cur.data : 16'h0000;
	assign host_data     = (cur.kind == K_TO_HOST) ? cur.data : 16'h0000;
	assign lba_supported = (cur.kind == K_ID_DONE) ? lba_sup_q : 1'b0;
	assign disk_sectors  = (cur.kind == K_ID_DONE) ? sectors_q : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= burst.count;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q     <= burst.ent;
			lba_sup_q <= burst.lba_sup;
			sectors_q <= burst.sectors;
		end
	end

	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q)
		else $error("burst index beyond burst length");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && burst.count != '0) |=> out_valid && idx_q == '0)
		else $error("loaded burst not presented");

endmodule

// ===== rtl/ata_pio_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// ata_pio_host_sequencer: ATA PIO single-sector LBA28 host sequencer
// Input register, sequencer step and result burst drain.
// ----------------------------------------------------------------------------
// Each input transfer (identify, read block, write block, a word returned by
// a drive bus read, or a host word to write) is captured in an input
// register; once the burst register is free, the sequencer updates its phase
// and builds the list of results the item causes (up to seven: the register
// setup of a read or write issues six bus writes and a status read). That
// list lands in the burst register and leaves one result per output transfer,
// so an item passes the input register and the burst register on its way
// out. The burst register sets the rate: an item that causes n results holds
// the output for n transfers, so with one result per item and no output stall
// the block takes one item every cycle; an item with no result (ignored
// command, stray word) does not hold up the next. A new item is taken while
// the previous burst drains, and is processed as the last result leaves.
// ----------------------------------------------------------------------------
module ata_pio_host_sequencer import ata_ps_pkg::*; #(
	parameter int BLOCK_BYTES    = 512,
	parameter int IDENTIFY_WORDS = 62
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [27:0] lba,
	input  logic [15:0] bus_word,
	input  logic [15:0] host_word,
	// result output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [4:0]  bus_address,
	output logic [15:0] bus_data,
	output logic [15:0] host_data,
	output logic        lba_supported,
	output logic [31:0] disk_sectors,
	output logic        last
);

	// words per block; a block is always at least one word
	localparam int BLOCK_WORDS = (BLOCK_BYTES / 2 == 0) ? 1 : BLOCK_BYTES / 2;

	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic [27:0] lba_s1;
	logic [15:0] bus_word_s1;
	logic [15:0] host_word_s1;
	logic        fire;
	logic        burst_free;
	logic        in_take;
	burst_t      burst;

	// process the held item once the burst register can take its results
	assign fire     = valid_s1 && burst_free;
	assign in_stall = valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	// payload: hold until the next transfer
	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1    <= opcode;
			lba_s1       <= lba;
			bus_word_s1  <= bus_word;
			host_word_s1 <= host_word;
		end
	end

	ata_ps_step #(
		.BLOCK_WORDS    (BLOCK_WORDS),
		.IDENTIFY_WORDS (IDENTIFY_WORDS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.opcode    (opcode_s1),
		.lba       (lba_s1),
		.bus_word  (bus_word_s1),
		.host_word (host_word_s1),
		.burst     (burst)
	);

	ata_ps_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.burst         (burst),
		.free          (burst_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.bus_address   (bus_address),
		.bus_data      (bus_data),
		.host_data     (host_data),
		.lba_supported (lba_supported),
		.disk_sectors  (disk_sectors),
		.last          (last)
	);

	a_stall_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled with nothing pending");

	a_fire_drops_item: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !in_take) |=> !valid_s1)
		else $error("processed item still held");

endmodule
